>>> hw/rtl/alist_pkg.sv
// Shared types and codes for the packed list engine.
package alist_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH
  } state_t;

  localparam int PosW = 8;
  localparam int ValW = 32;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic            ins;
    logic            del;
    logic            cmp;
    logic [PosW-1:0] slot;   // zero-based target slot
    logic [ValW-1:0] value;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/alist_cell.sv
// One list slot: holds an entry, shifts with its neighbours, compares for search.
module alist_cell #(
  parameter int K  = 0,
  parameter int CW = 8
) (
  input  logic                       clk,
  input  alist_pkg::cell_ctrl_t      ctrl,
  input  logic [CW-1:0]              count,
  input  logic [alist_pkg::ValW-1:0] left_data,
  input  logic [alist_pkg::ValW-1:0] right_data,
  output logic [alist_pkg::ValW-1:0] data,
  output logic                       match
);

  localparam int SW = (CW > alist_pkg::PosW) ? CW : alist_pkg::PosW;
  localparam logic [SW-1:0] Idx = SW'(K);

  logic [SW-1:0] slot_ext;
  logic [SW-1:0] cnt_ext;
  logic          in_list;

  assign slot_ext = SW'(ctrl.slot);
  assign cnt_ext  = SW'(count);
  assign in_list  = Idx < cnt_ext;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (Idx == slot_ext) begin
        data <= ctrl.value;
      end else if (Idx > slot_ext) begin
        data <= left_data;
      end
    end else if (ctrl.del) begin
      if (Idx >= slot_ext) begin
        data <= right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      match <= in_list && (data == ctrl.value);
    end
  end

endmodule

>>> hw/rtl/alist_ffs.sv
// Registered binary tree that finds the lowest set match bit.
module alist_ffs #(
  parameter int N  = 128,
  parameter int IW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [N-1:0]  leaves,
  output logic          out_valid,
  output logic          found,
  output logic [IW-1:0] index
);

  localparam int NP = 1 << IW;

  logic [NP-1:0] leaf;
  logic [IW-1:0] vld;

  assign leaf = NP'(leaves);

  for (genvar lv = 0; lv <= IW; lv++) begin : g_lvl
    localparam int W = NP >> lv;
    logic [W-1:0]  hit;
    logic [IW-1:0] pos [W];
    if (lv == 0) begin : g_leaf
      assign hit = leaf;
      for (genvar j = 0; j < W; j++) begin : g_pos
        assign pos[j] = IW'(j);
      end
    end else begin : g_node
      always_ff @(posedge clk) begin
        for (int j = 0; j < W; j++) begin
          hit[j] <= g_lvl[lv-1].hit[2*j] || g_lvl[lv-1].hit[2*j+1];
          pos[j] <= g_lvl[lv-1].hit[2*j] ? g_lvl[lv-1].pos[2*j] :
                                           g_lvl[lv-1].pos[2*j+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= IW'({vld, in_valid});
    end
  end

  assign out_valid = vld[IW-1];
  assign found     = g_lvl[IW].hit[0];
  assign index     = g_lvl[IW].pos[0];

endmodule

>>> hw/rtl/array_list_insert_delete_search_core.sv
// Top level of the packed list engine: command control, cell chain and match tree.
//
// Usage: present mode, position and value with start high; the request is
// taken at the rising edge where start is high and busy is low. busy stays
// high while the request is worked on and drops in the cycle in which the
// result is shown, so a new request may be taken at the end of that cycle.
// Each result (status, found_position, list_length) is valid for exactly one
// cycle while strobe is high; the receiver cannot stall it.
// Insert, delete and unused modes: the request is registered into the EXEC
// state, then the result is registered from it; no new request is taken
// until that result is shown. The cell chain shifts every entry from the
// target slot onward at the same edge. Search: all cells compare at once,
// then the match tree reduces the match bits one registered level at a time.
// Reset (rst, synchronous) empties the list and cancels any request in
// flight; the stored entries themselves are not cleared.
module array_list_insert_delete_search_core #(
  parameter int DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  position,
  input  logic [31:0] value,
  output logic        strobe,
  output logic [1:0]  status,
  output logic [7:0]  found_position,
  output logic [7:0]  list_length
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > 8) ? CW : 8) + 1;

  alist_pkg::state_t     state, state_next;
  alist_pkg::mode_t      req_mode;
  logic [7:0]            req_position;
  logic [31:0]           req_value;
  logic [CW-1:0]         count, count_next;
  alist_pkg::cell_ctrl_t ctrl;
  logic                  srch_go;

  logic [31:0]           data [DEPTH];
  logic [DEPTH-1:0]      match;

  logic                  tree_valid;
  logic                  tree_found;
  logic [IW-1:0]         tree_index;

  logic                  strobe_next;
  alist_pkg::status_t    status_next;
  logic [7:0]            found_next;
  logic [7:0]            length_next;

  logic [PW-1:0]         pos_ext;
  logic [PW-1:0]         cnt_ext;
  logic                  ins_pos_ok;
  logic                  del_pos_ok;
  logic                  is_full;
  logic [CW-1:0]         hit_pos;

  assign busy       = (state != alist_pkg::S_IDLE);
  assign pos_ext    = PW'(req_position);
  assign cnt_ext    = PW'(count);
  assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + PW'(1));
  assign del_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign is_full    = (count == CW'(DEPTH));
  assign hit_pos    = CW'(tree_index) + CW'(1);

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_mode     <= alist_pkg::mode_t'(mode);
      req_position <= position;
      req_value    <= value;
    end
  end

  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.del   = 1'b0;
    ctrl.cmp   = 1'b0;
    ctrl.slot  = req_position - 8'd1;
    ctrl.value = req_value;
    state_next  = state;
    count_next  = count;
    strobe_next = 1'b0;
    status_next = alist_pkg::ST_OK;
    found_next  = '0;
    length_next = 8'(count);
    unique case (state)
      alist_pkg::S_IDLE: begin
        if (start) begin
          state_next = alist_pkg::S_EXEC;
        end
      end
      alist_pkg::S_EXEC: begin
        unique case (req_mode)
          alist_pkg::MODE_INSERT: begin
            if (!ins_pos_ok) begin
              status_next = alist_pkg::ST_BADPOS;
            end else if (is_full) begin
              status_next = alist_pkg::ST_FULL;
            end else begin
              ctrl.ins   = 1'b1;
              count_next = count + CW'(1);
            end
          end
          alist_pkg::MODE_DELETE: begin
            if (!del_pos_ok) begin
              status_next = alist_pkg::ST_BADPOS;
            end else begin
              ctrl.del   = 1'b1;
              count_next = count - CW'(1);
            end
          end
          alist_pkg::MODE_SEARCH: begin
            ctrl.cmp = 1'b1;
          end
          alist_pkg::MODE_NONE: begin
          end
          default: begin
          end
        endcase
        length_next = 8'(count_next);
        if (req_mode == alist_pkg::MODE_SEARCH) begin
          state_next = alist_pkg::S_SRCH;
        end else begin
          strobe_next = 1'b1;
          state_next  = alist_pkg::S_IDLE;
        end
      end
      alist_pkg::S_SRCH: begin
        if (tree_valid) begin
          strobe_next = 1'b1;
          state_next  = alist_pkg::S_IDLE;
          if (tree_found) begin
            found_next = 8'(hit_pos);
          end else begin
            status_next = alist_pkg::ST_NOTFOUND;
          end
        end
      end
      default: begin
        state_next = alist_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= alist_pkg::S_IDLE;
      count   <= '0;
      srch_go <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      srch_go <= ctrl.cmp;
      strobe  <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    status         <= status_next;
    found_position <= found_next;
    list_length    <= length_next;
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [31:0] left_d;
    logic [31:0] right_d;
    if (k == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = data[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_d = data[k];
    end else begin : g_mid_r
      assign right_d = data[k+1];
    end
    alist_cell #(
      .K  (k),
      .CW (CW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (data[k]),
      .match      (match[k])
    );
  end

  alist_ffs #(
    .N  (DEPTH),
    .IW (IW)
  ) u_ffs (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (srch_go),
    .leaves    (match),
    .out_valid (tree_valid),
    .found     (tree_found),
    .index     (tree_index)
  );

endmodule
